@@ design/wlr_pkg.sv @@
// Shared types, constants and helper functions for the line-fit core.
package wlr_pkg;

  localparam int unsigned DW = 128;
  localparam logic [31:0] WIN_TIME_RST = 32'd1000000;

  typedef enum logic [1:0] {
    DIV_WIN   = 2'd0,
    DIV_DEC   = 2'd1,
    DIV_SLOPE = 2'd2,
    DIV_ICPT  = 2'd3
  } div_sel_t;

  typedef enum logic [2:0] {
    MUL_NXX = 3'd0,
    MUL_XX  = 3'd1,
    MUL_NXY = 3'd2,
    MUL_XY  = 3'd3,
    MUL_SX  = 3'd4
  } mul_sel_t;

  localparam logic [1:0] SUM_X    = 2'd0;
  localparam logic [1:0] SUM_Y    = 2'd1;
  localparam logic [1:0] SUM_XX   = 2'd2;
  localparam logic [1:0] SUM_XY   = 2'd3;
  localparam logic [1:0] SUM_LAST = SUM_XY;

  typedef struct packed {
    logic     load;
    logic     div_go;
    div_sel_t div_sel;
    logic [1:0] idx;
    logic     win_wr;
    logic     dec_wr;
    logic     add_wr;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     mul_wr;
    logic     slope_wr;
    logic     icpt_wr;
    logic     res_wr;
  } wlr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic need_decay;
    logic n_gt1;
    logic den_ok;
  } wlr_sts_t;

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(64'd0 - v) : v;
  endfunction

  function automatic logic [DW-1:0] abs128(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'({DW{1'b0}} - v) : v;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic [31:0] sat_s32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  // quotient magnitude with sign applied, saturated to 32 bits
  function automatic logic [31:0] sat_q32(input logic neg, input logic ovf,
                                          input logic [63:0] q);
    logic [63:0] nq;
    nq = 64'd0 - q;
    if (neg) begin
      if (ovf || q > 64'h80000000) return 32'h80000000;
      return nq[31:0];
    end
    if (ovf || q > 64'h7FFFFFFF) return 32'h7FFFFFFF;
    return q[31:0];
  endfunction

endpackage

@@ design/wlr_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module wlr_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [wlr_pkg::DW-1:0] dvd,
  input  logic [wlr_pkg::DW-1:0] dvs,
  input  logic [7:0]             steps,
  output logic [63:0]            q,
  output logic                   ovf,
  output logic                   done
);
  import wlr_pkg::*;

  logic          busy_r, done_r, ovf_r;
  logic [7:0]    cnt_r;
  logic [DW-1:0] rem_r, dvd_r, dvs_r;
  logic [63:0]   q_r;
  logic [DW:0]   rs;
  logic [DW+1:0] diff;
  logic          ge;

  assign rs   = {rem_r, dvd_r[DW-1]};
  assign diff = {1'b0, rs} - {2'b00, dvs_r};
  assign ge   = !diff[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 8'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      dvd_r <= dvd;
      dvs_r <= dvs;
      q_r   <= '0;
      ovf_r <= 1'b0;
      cnt_r <= steps;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : rs[DW-1:0];
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      ovf_r <= ovf_r | q_r[63];
      q_r   <= {q_r[62:0], ge};
      cnt_r <= cnt_r - 8'd1;
    end
  end

  assign q    = q_r;
  assign ovf  = ovf_r;
  assign done = done_r;

endmodule

@@ design/wlr_mul.sv @@
// Signed 64x64 multiplier built from four registered 32x32 partial products.
module wlr_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic signed [63:0]            a,
  input  logic signed [63:0]            b,
  output logic signed [wlr_pkg::DW-1:0] p,
  output logic                          done
);
  import wlr_pkg::*;

  logic          busy_r, done_r, neg_r;
  logic [2:0]    cnt_r;
  logic [63:0]   ma_r, mb_r, pp_r;
  logic [1:0]    sh_r;
  logic [DW-1:0] acc_r, p_r;
  logic [31:0]   ah, bh;

  assign ah = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign bh = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 3'd5) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ma_r  <= abs64(a);
      mb_r  <= abs64(b);
      neg_r <= a[63] ^ b[63];
      acc_r <= '0;
      cnt_r <= 3'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (!cnt_r[2]) begin
        pp_r <= ah * bh;
        sh_r <= 2'({1'b0, cnt_r[1]} + {1'b0, cnt_r[0]});
      end
      if (cnt_r != 3'd0 && cnt_r != 3'd5) begin
        acc_r <= acc_r + ({64'd0, pp_r} << {sh_r, 5'd0});
      end
      if (cnt_r == 3'd5) begin
        p_r <= neg_r ? DW'({DW{1'b0}} - acc_r) : acc_r;
      end
    end
  end

  assign p    = p_r;
  assign done = done_r;

endmodule

@@ design/wlr_dp.sv @@
// Datapath: running sums, window count, normal-equation terms and results.
module wlr_dp #(
  parameter int MAX_WINDOW = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wlr_pkg::wlr_cmd_t cmd,
  output wlr_pkg::wlr_sts_t sts,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  logic [47:0]       in_tdata,
  output logic [63:0]       out_tdata,
  output logic              out_tuser
);
  import wlr_pkg::*;

  localparam int          WW    = $clog2(MAX_WINDOW + 1);
  localparam logic [63:0] THR   = (64'd1 << (2 * FRAC_BITS)) / 64'd100000;
  localparam logic [63:0] MAXW  = 64'(MAX_WINDOW);
  localparam logic [7:0]  SLOPE_STEPS = 8'(DW + FRAC_BITS);

  logic signed [15:0] in_x, in_y;
  logic        [15:0] in_p;
  assign in_x = in_tdata[15:0];
  assign in_y = in_tdata[31:16];
  assign in_p = in_tdata[47:32];

  logic [31:0]              wt_r;
  logic [WW-1:0]            count_r;
  logic signed [63:0]       sum_r [4];
  logic signed [15:0]       x_r, y_r;
  logic signed [DW-1:0]     acc_r, den_r;
  logic [31:0]              slope_r, icpt_r;
  logic                     fit_r;
  logic [31:0]              out_slope_r, out_icpt_r;
  logic                     out_fit_r;

  // divider and multiplier
  logic [DW-1:0]        div_dvd, div_dvs;
  logic [7:0]           div_steps;
  logic [63:0]          div_q;
  logic                 div_ovf, div_done;
  logic signed [63:0]   mul_a, mul_b;
  logic signed [DW-1:0] mul_p;
  logic                 mul_done;

  wlr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .steps (div_steps),
    .q     (div_q),
    .ovf   (div_ovf),
    .done  (div_done)
  );

  wlr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .done  (mul_done)
  );

  always_comb begin
    unique case (cmd.div_sel)
      DIV_WIN: begin
        div_dvd   = {wt_r, 96'd0};
        div_dvs   = DW'(in_p);
        div_steps = 8'd32;
      end
      DIV_DEC: begin
        div_dvd   = {abs64(sum_r[cmd.idx]), 64'd0};
        div_dvs   = DW'(count_r);
        div_steps = 8'd64;
      end
      DIV_SLOPE: begin
        div_dvd   = abs128(acc_r);
        div_dvs   = abs128(den_r);
        div_steps = SLOPE_STEPS;
      end
      DIV_ICPT: begin
        div_dvd   = abs128(acc_r);
        div_dvs   = DW'(count_r) << FRAC_BITS;
        div_steps = 8'd128;
      end
      default: begin
        div_dvd   = '0;
        div_dvs   = '0;
        div_steps = 8'd0;
      end
    endcase
  end

  logic signed [63:0] n64;
  assign n64 = 64'(count_r);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_NXX: begin mul_a = n64;              mul_b = sum_r[SUM_XX]; end
      MUL_XX:  begin mul_a = sum_r[SUM_X];     mul_b = sum_r[SUM_X];  end
      MUL_NXY: begin mul_a = n64;              mul_b = sum_r[SUM_XY]; end
      MUL_XY:  begin mul_a = sum_r[SUM_X];     mul_b = sum_r[SUM_Y];  end
      MUL_SX:  begin mul_a = 64'(signed'(slope_r)); mul_b = sum_r[SUM_X]; end
      default: begin mul_a = '0;               mul_b = '0;            end
    endcase
  end

  // window length from the quotient window_time / period, then sample count
  logic [WW-1:0] win;
  logic [WW:0]   n_inc;
  logic          need_decay;
  logic [WW-1:0] n_new;

  always_comb begin
    if (div_q == 64'd0)    win = WW'(1);
    else if (div_q > MAXW) win = WW'(MAX_WINDOW);
    else                   win = div_q[WW-1:0];
    n_inc      = {1'b0, count_r} + (WW+1)'(1);
    need_decay = n_inc > {1'b0, win};
    n_new      = need_decay ? win : n_inc[WW-1:0];
  end

  // new terms of the four sums
  logic signed [31:0] xx, xy;
  logic signed [63:0] t_x, t_y, t_xx, t_xy;
  assign xx   = x_r * x_r;
  assign xy   = x_r * y_r;
  assign t_x  = 64'(x_r) <<< FRAC_BITS;
  assign t_y  = 64'(y_r) <<< FRAC_BITS;
  assign t_xx = 64'(xx) <<< FRAC_BITS;
  assign t_xy = 64'(xy) <<< FRAC_BITS;

  logic signed [63:0] dec_s, dec_q;
  assign dec_s = sum_r[cmd.idx];
  assign dec_q = dec_s[63] ? 64'(64'd0 - div_q) : div_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r     <= WIN_TIME_RST;
      count_r  <= '0;
      sum_r[0] <= '0;
      sum_r[1] <= '0;
      sum_r[2] <= '0;
      sum_r[3] <= '0;
    end else begin
      if (cfg_wr_en) wt_r <= cfg_wr_data;
      if (cmd.win_wr) count_r <= n_new;
      if (cmd.dec_wr) sum_r[cmd.idx] <= dec_s - dec_q;
      if (cmd.add_wr) begin
        sum_r[SUM_X]  <= sat_add64(sum_r[SUM_X], t_x);
        sum_r[SUM_Y]  <= sat_add64(sum_r[SUM_Y], t_y);
        sum_r[SUM_XX] <= sat_add64(sum_r[SUM_XX], t_xx);
        sum_r[SUM_XY] <= sat_add64(sum_r[SUM_XY], t_xy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_x;
      y_r     <= in_y;
      slope_r <= '0;
      icpt_r  <= sat_s32(64'(in_y) <<< FRAC_BITS);
      fit_r   <= 1'b0;
    end
    if (cmd.mul_wr) begin
      unique case (cmd.mul_sel)
        MUL_NXX: acc_r <= mul_p << FRAC_BITS;
        MUL_XX:  den_r <= acc_r - mul_p;
        MUL_NXY: acc_r <= mul_p << FRAC_BITS;
        MUL_XY:  acc_r <= acc_r - mul_p;
        MUL_SX:  acc_r <= (DW'(sum_r[SUM_Y]) <<< FRAC_BITS) - mul_p;
        default: acc_r <= acc_r;
      endcase
    end
    if (cmd.slope_wr) slope_r <= sat_q32(acc_r[DW-1] ^ den_r[DW-1], div_ovf, div_q);
    if (cmd.icpt_wr) begin
      icpt_r <= sat_q32(acc_r[DW-1], div_ovf, div_q);
      fit_r  <= 1'b1;
    end
    if (cmd.res_wr) begin
      out_slope_r <= slope_r;
      out_icpt_r  <= icpt_r;
      out_fit_r   <= fit_r;
    end
  end

  assign sts.div_done   = div_done;
  assign sts.mul_done   = mul_done;
  assign sts.need_decay = need_decay;
  assign sts.n_gt1      = count_r > WW'(1);
  assign sts.den_ok     = abs128(den_r) > DW'(THR);

  assign out_tdata = {out_icpt_r, out_slope_r};
  assign out_tuser = out_fit_r;

endmodule

@@ design/wlr_ctrl.sv @@
// Controller: sequences window divide, decay, sum update and the line solve.
module wlr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output wlr_pkg::wlr_cmd_t cmd,
  input  wlr_pkg::wlr_sts_t sts
);
  import wlr_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_WIN      = 11'b00000000010,
    S_DEC_GO   = 11'b00000000100,
    S_DEC_WAIT = 11'b00000001000,
    S_SUMS     = 11'b00000010000,
    S_MUL_GO   = 11'b00000100000,
    S_MUL_WAIT = 11'b00001000000,
    S_CHECK    = 11'b00010000000,
    S_DIV_GO   = 11'b00100000000,
    S_DIV_WAIT = 11'b01000000000,
    S_RESULT   = 11'b10000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  mul_sel_t   msel_r, msel_nxt;
  div_sel_t   dsel_r, dsel_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    msel_nxt    = msel_r;
    dsel_nxt    = dsel_r;
    cmd         = '0;
    cmd.div_sel = dsel_r;
    cmd.idx     = idx_r;
    cmd.mul_sel = msel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load    = 1'b1;
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_WIN;
          state_nxt   = S_WIN;
        end
      end
      S_WIN: begin
        if (sts.div_done) begin
          cmd.win_wr = 1'b1;
          idx_nxt    = SUM_X;
          state_nxt  = sts.need_decay ? S_DEC_GO : S_SUMS;
        end
      end
      S_DEC_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_DEC;
        state_nxt   = S_DEC_WAIT;
      end
      S_DEC_WAIT: begin
        cmd.div_sel = DIV_DEC;
        if (sts.div_done) begin
          cmd.dec_wr = 1'b1;
          if (idx_r == SUM_LAST) begin
            state_nxt = S_SUMS;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_DEC_GO;
          end
        end
      end
      S_SUMS: begin
        cmd.add_wr = 1'b1;
        if (sts.n_gt1) begin
          msel_nxt  = MUL_NXX;
          state_nxt = S_MUL_GO;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_MUL_GO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (sts.mul_done) begin
          cmd.mul_wr = 1'b1;
          unique case (msel_r)
            MUL_NXX: begin msel_nxt = MUL_XX; state_nxt = S_MUL_GO; end
            MUL_XX:  state_nxt = S_CHECK;
            MUL_NXY: begin msel_nxt = MUL_XY; state_nxt = S_MUL_GO; end
            MUL_XY:  begin dsel_nxt = DIV_SLOPE; state_nxt = S_DIV_GO; end
            MUL_SX:  begin dsel_nxt = DIV_ICPT; state_nxt = S_DIV_GO; end
            default: state_nxt = S_RESULT;
          endcase
        end
      end
      S_CHECK: begin
        if (sts.den_ok) begin
          msel_nxt  = MUL_NXY;
          state_nxt = S_MUL_GO;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          if (dsel_r == DIV_SLOPE) begin
            cmd.slope_wr = 1'b1;
            msel_nxt     = MUL_SX;
            state_nxt    = S_MUL_GO;
          end else begin
            cmd.icpt_wr = 1'b1;
            state_nxt   = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.res_wr = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.res_wr)      out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
    else                 out_tvalid_nxt = out_tvalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= SUM_X;
      msel_r       <= MUL_NXX;
      dsel_r       <= DIV_WIN;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      msel_r       <= msel_nxt;
      dsel_r       <= dsel_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

endmodule

@@ design/windowed_linear_regression_core.sv @@
// Windowed least-squares line fit core (top level).
// One word is in flight at a time; most of the work per word is done by the
// bit-serial divider (32 steps window, 64 per decayed sum, 128+FRAC_BITS slope,
// 128 intercept).
// A finished word waits in the output register while the next is taken.
// Reset (rst_n low, synchronous) clears count and sums, window_time = 1000000.
module windowed_linear_regression_core #(
  parameter int MAX_WINDOW = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,  // window_time
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,     // x_sample, y_sample, sample_period
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,    // slope, intercept
  output logic        out_tuser     // fit_valid
);
  import wlr_pkg::*;

  wlr_cmd_t cmd;
  wlr_sts_t sts;

  wlr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  wlr_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
